### sv/longest_consecutive_run_length_defines.svh
// assertion macros for the longest consecutive run length block
// included by the modules that carry concurrent checks; no other dependencies
`ifndef LONGEST_CONSECUTIVE_RUN_LENGTH_DEFINES_SVH
`define LONGEST_CONSECUTIVE_RUN_LENGTH_DEFINES_SVH

`ifndef ASSERT_OFF
// check on the rising clock, quiet while reset is held
`define LCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lcr assertion failed");
// check on the rising clock, also while reset is held
`define LCR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lcr assertion failed");
`else
`define LCR_ASSERT(lbl, clk, rst_n, prop)
`define LCR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### sv/lcr_pkg.sv
// shared constants, types and cell control word for the run length block
// no dependencies
`default_nettype none

package lcr_pkg;

  localparam int MAX_ITEMS = 256;
  localparam int VALUE_W   = 30;
  localparam int OUT_RUN_W = 9;
  // count has to hold MAX_ITEMS itself
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int RUN_W     = (CNT_W > OUT_RUN_W) ? CNT_W : OUT_RUN_W;

  localparam logic [OUT_RUN_W-1:0] RUN_MAX = '1;

  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [RUN_W-1:0]     run_t;
  typedef logic [OUT_RUN_W-1:0] out_run_t;

  // broadcast to every sort cell
  typedef struct packed {
    logic   ins;
    logic   drain;
    value_t value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### sv/lcr_if.sv
// valid/ready channel interfaces for the input word and the result word
// uses lcr_pkg for the payload types
`default_nettype none

interface lcr_in_if;
  logic                valid;
  logic                ready;
  lcr_pkg::value_t     value;
  logic                last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface lcr_out_if;
  logic                valid;
  logic                ready;
  lcr_pkg::out_run_t   longest_run;
  logic                dropped;

  modport source (output valid, output longest_run, output dropped, input ready);
  modport sink   (input valid, input longest_run, input dropped, output ready);
endinterface

`default_nettype wire

### sv/longest_consecutive_run_length.sv
// Longest consecutive run length, top level.
// A set of 30-bit unsigned values arrives on in_if, one word per cycle while
// in_if.ready is high, the final word of the set flagged by last. Each word is
// placed in sorted order by a chain of MAX_ITEMS cells (256) as it arrives.
// Words that arrive while the chain is full are discarded and flagged.
// After the last word, the chain shifts down one entry per cycle into a run
// scanner, and the result register is loaded once the chain is empty.
// in_if.ready is low while the chain drains. out_if then carries longest_run
// (saturated at 511) and dropped. The result register waits for out_if.ready;
// a new set may be loaded meanwhile, and its own drain holds at the end until
// the register frees. Reset (rst_n low, synchronous) empties the chain count,
// clears the drop flag and the pending result; no clearing pass is needed.
// Depends on lcr_pkg, lcr_if, lcr_cell, lcr_scan and the defines header.
`default_nettype none
`include "longest_consecutive_run_length_defines.svh"

module longest_consecutive_run_length (
  input  wire         clk,
  input  wire         rst_n,
  lcr_in_if.sink      in_if,
  lcr_out_if.source   out_if
);

  typedef enum logic {S_LOAD, S_DRAIN} state_t;

  localparam int N = lcr_pkg::MAX_ITEMS;

  state_t              state_r;
  lcr_pkg::cnt_t       count_r;
  logic                overflow_r;
  logic                out_valid_r;
  lcr_pkg::out_run_t   out_run_r;
  logic                out_drop_r;

  lcr_pkg::cell_ctrl_t ctrl;
  lcr_pkg::value_t     cell_val [N];
  logic                cell_gt  [N];
  logic                occ      [N];
  lcr_pkg::run_t       best;
  lcr_pkg::out_run_t   best_sat;

  logic accept;
  logic full;
  logic drain_step;
  logic finish;
  logic slot_free;

  assign in_if.ready = (state_r == S_LOAD);
  assign accept      = in_if.valid && in_if.ready;
  assign full        = (count_r == lcr_pkg::CNT_W'(N));
  assign drain_step  = (state_r == S_DRAIN) && (count_r != '0);
  assign slot_free   = !out_valid_r || out_if.ready;
  assign finish      = (state_r == S_DRAIN) && (count_r == '0) && slot_free;

  assign ctrl.ins   = accept && !full;
  assign ctrl.drain = drain_step;
  assign ctrl.value = in_if.value;

  genvar gi;
  generate
    for (gi = 0; gi < N; gi++) begin : g_cell
      assign occ[gi] = (count_r > lcr_pkg::CNT_W'(gi));
      if (gi == 0 && N > 1) begin : g_head
        lcr_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occ[gi]),
          .left_val  ('0),
          .left_gt   (1'b0),
          .right_val (cell_val[gi+1]),
          .val       (cell_val[gi]),
          .gt        (cell_gt[gi])
        );
      end else if (gi == N - 1) begin : g_tail
        lcr_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occ[gi]),
          .left_val  (cell_val[gi-1]),
          .left_gt   (cell_gt[gi-1]),
          .right_val (cell_val[gi]),
          .val       (cell_val[gi]),
          .gt        (cell_gt[gi])
        );
      end else begin : g_mid
        lcr_cell u_cell (
          .clk       (clk),
          .ctrl      (ctrl),
          .occupied  (occ[gi]),
          .left_val  (cell_val[gi-1]),
          .left_gt   (cell_gt[gi-1]),
          .right_val (cell_val[gi+1]),
          .val       (cell_val[gi]),
          .gt        (cell_gt[gi])
        );
      end
    end
  endgenerate

  lcr_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept && in_if.last),
    .step  (drain_step),
    .value (cell_val[0]),
    .best  (best)
  );

  assign best_sat = (best > lcr_pkg::RUN_W'(lcr_pkg::RUN_MAX)) ?
                    lcr_pkg::RUN_MAX : best[lcr_pkg::OUT_RUN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a finishing set refills the register in the cycle it empties
      if (out_valid_r && out_if.ready && !finish) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              overflow_r <= 1'b1;
            end else begin
              count_r <= count_r + lcr_pkg::CNT_W'(1);
            end
            if (in_if.last) begin
              state_r <= S_DRAIN;
            end
          end
        end
        S_DRAIN: begin
          if (drain_step) begin
            count_r <= count_r - lcr_pkg::CNT_W'(1);
          end else if (finish) begin
            out_valid_r <= 1'b1;
            out_run_r   <= best_sat;
            out_drop_r  <= overflow_r;
            overflow_r  <= 1'b0;
            state_r     <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.longest_run = out_run_r;
  assign out_if.dropped     = out_drop_r;

  `LCR_ASSERT(a_count_bound, clk, rst_n, count_r <= lcr_pkg::CNT_W'(N))
  `LCR_ASSERT(a_full_sets_drop, clk, rst_n, (accept && full) |=> overflow_r)
  `LCR_ASSERT(a_drain_counts_down, clk, rst_n, drain_step |=> (count_r == $past(count_r) - lcr_pkg::CNT_W'(1)))
  `LCR_ASSERT(a_finish_loads_result, clk, rst_n, finish |=> (out_valid_r && state_r == S_LOAD && !overflow_r))
  `LCR_ASSERT_ALWAYS(a_no_overwrite, clk, (rst_n && out_valid_r && !out_if.ready) |=> (!rst_n || out_valid_r))

endmodule

`default_nettype wire

### sv/lcr_cell.sv
// one cell of the insertion sort chain: holds one stored value
// shifts up on insert, shifts down on drain; uses lcr_pkg
`default_nettype none

module lcr_cell (
  input  wire                      clk,
  input  wire lcr_pkg::cell_ctrl_t ctrl,
  input  wire                      occupied,
  input  wire lcr_pkg::value_t     left_val,
  input  wire                      left_gt,
  input  wire lcr_pkg::value_t     right_val,
  output lcr_pkg::value_t          val,
  output logic                     gt
);

  lcr_pkg::value_t val_r;
  lcr_pkg::value_t val_nxt;

  assign gt  = occupied && (val_r > ctrl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      // new word lands here, or the neighbor below moves up
      if (gt || !occupied) begin
        val_nxt = left_gt ? left_val : ctrl.value;
      end
    end else if (ctrl.drain) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

### sv/lcr_scan.sv
// run scanner fed with the sorted values one per cycle from the chain head
// tracks current run and best run; uses lcr_pkg
`default_nettype none

module lcr_scan (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire                  step,
  input  wire lcr_pkg::value_t value,
  output lcr_pkg::run_t        best
);

  logic            have_r;
  lcr_pkg::value_t prev_r;
  lcr_pkg::run_t   run_r;
  lcr_pkg::run_t   best_r;
  logic            dup;
  logic            succ;
  lcr_pkg::run_t   run_nxt;
  lcr_pkg::run_t   best_nxt;

  always_comb begin
    dup      = have_r && (value == prev_r);
    succ     = have_r && ({1'b0, value} == ({1'b0, prev_r} + (lcr_pkg::VALUE_W + 1)'(1)));
    run_nxt  = succ ? (run_r + lcr_pkg::RUN_W'(1)) : lcr_pkg::RUN_W'(1);
    best_nxt = (run_nxt > best_r) ? run_nxt : best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      run_r  <= '0;
      best_r <= lcr_pkg::RUN_W'(1);
    end else if (start) begin
      have_r <= 1'b0;
      run_r  <= '0;
      best_r <= lcr_pkg::RUN_W'(1);
    end else if (step && !dup) begin
      // duplicates neither break nor extend a run
      have_r <= 1'b1;
      run_r  <= run_nxt;
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !dup) begin
      prev_r <= value;
    end
  end

  assign best = best_r;

endmodule

`default_nettype wire
